/* src/lttu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lttu_pkg;

    typedef enum logic [2:0] {
        ENC_COPY    = 3'd0,
        ENC_LATIN1  = 3'd1,
        ENC_LATIN9  = 3'd2,
        ENC_CP1252  = 3'd3,
        ENC_MAC     = 3'd4,
        ENC_UTF16LE = 3'd5,
        ENC_UTF16BE = 3'd6,
        ENC_OTHER   = 3'd7
    } enc_t;

    localparam logic [0:0] REG_SOURCE_ENCODING = 1'b0;
    localparam logic [0:0] REG_SKIP_COUNT      = 1'b1;

    localparam logic [20:0] REPL_CHAR = 21'h00FFFD;
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified work item: up to two code points, or one raw byte followed by at most one code point.
    typedef struct packed {
        logic        raw;       // emit raw_byte unchanged
        logic [7:0]  raw_byte;
        logic        cp0_en;
        logic [20:0] cp0;
        logic        cp1_en;
        logic [20:0] cp1;
    } work_t;

    function automatic logic [15:0] cp1252_map(input logic [4:0] i);
        logic [15:0] r;
        begin
            case (i)
                5'd0:  r = 16'h20AC; 5'd1:  r = 16'h0081; 5'd2:  r = 16'h201A;
                5'd3:  r = 16'h0192; 5'd4:  r = 16'h201E; 5'd5:  r = 16'h2026;
                5'd6:  r = 16'h2020; 5'd7:  r = 16'h2021; 5'd8:  r = 16'h02C6;
                5'd9:  r = 16'h2030; 5'd10: r = 16'h0160; 5'd11: r = 16'h2039;
                5'd12: r = 16'h0152; 5'd13: r = 16'h008D; 5'd14: r = 16'h017D;
                5'd15: r = 16'h008F; 5'd16: r = 16'h0090; 5'd17: r = 16'h2018;
                5'd18: r = 16'h2019; 5'd19: r = 16'h201C; 5'd20: r = 16'h201D;
                5'd21: r = 16'h2022; 5'd22: r = 16'h2013; 5'd23: r = 16'h2014;
                5'd24: r = 16'h02DC; 5'd25: r = 16'h2122; 5'd26: r = 16'h0161;
                5'd27: r = 16'h203A; 5'd28: r = 16'h0153; 5'd29: r = 16'h009D;
                5'd30: r = 16'h017E; default: r = 16'h0178;
            endcase
            return r;
        end
    endfunction

    function automatic logic [15:0] mac_map(input logic [6:0] i);
        logic [15:0] r;
        begin
            case (i)
                7'd0: r = 16'h00C4; 7'd1: r = 16'h00C5; 7'd2: r = 16'h00C7;
                7'd3: r = 16'h00C9; 7'd4: r = 16'h00D1; 7'd5: r = 16'h00D6;
                7'd6: r = 16'h00DC; 7'd7: r = 16'h00E1; 7'd8: r = 16'h00E0;
                7'd9: r = 16'h00E2; 7'd10: r = 16'h00E4; 7'd11: r = 16'h00E3;
                7'd12: r = 16'h00E5; 7'd13: r = 16'h00E7; 7'd14: r = 16'h00E9;
                7'd15: r = 16'h00E8; 7'd16: r = 16'h00EA; 7'd17: r = 16'h00EB;
                7'd18: r = 16'h00ED; 7'd19: r = 16'h00EC; 7'd20: r = 16'h00EE;
                7'd21: r = 16'h00EF; 7'd22: r = 16'h00F1; 7'd23: r = 16'h00F3;
                7'd24: r = 16'h00F2; 7'd25: r = 16'h00F4; 7'd26: r = 16'h00F6;
                7'd27: r = 16'h00F5; 7'd28: r = 16'h00FA; 7'd29: r = 16'h00F9;
                7'd30: r = 16'h00FB; 7'd31: r = 16'h00FC; 7'd32: r = 16'h2020;
                7'd33: r = 16'h00B0; 7'd34: r = 16'h00A2; 7'd35: r = 16'h00A3;
                7'd36: r = 16'h00A7; 7'd37: r = 16'h2022; 7'd38: r = 16'h00B6;
                7'd39: r = 16'h00DF; 7'd40: r = 16'h00AE; 7'd41: r = 16'h00A9;
                7'd42: r = 16'h2122; 7'd43: r = 16'h00B4; 7'd44: r = 16'h00A8;
                7'd45: r = 16'h2260; 7'd46: r = 16'h00C6; 7'd47: r = 16'h00D8;
                7'd48: r = 16'h221E; 7'd49: r = 16'h00B1; 7'd50: r = 16'h2264;
                7'd51: r = 16'h2265; 7'd52: r = 16'h00A5; 7'd53: r = 16'h00B5;
                7'd54: r = 16'h2202; 7'd55: r = 16'h2211; 7'd56: r = 16'h220F;
                7'd57: r = 16'h03C0; 7'd58: r = 16'h222B; 7'd59: r = 16'h00AA;
                7'd60: r = 16'h00BA; 7'd61: r = 16'h03A9; 7'd62: r = 16'h00E6;
                7'd63: r = 16'h00F8; 7'd64: r = 16'h00BF; 7'd65: r = 16'h00A1;
                7'd66: r = 16'h00AC; 7'd67: r = 16'h221A; 7'd68: r = 16'h0192;
                7'd69: r = 16'h2248; 7'd70: r = 16'h2206; 7'd71: r = 16'h00AB;
                7'd72: r = 16'h00BB; 7'd73: r = 16'h2026; 7'd74: r = 16'h00A0;
                7'd75: r = 16'h00C0; 7'd76: r = 16'h00C3; 7'd77: r = 16'h00D5;
                7'd78: r = 16'h0152; 7'd79: r = 16'h0153; 7'd80: r = 16'h2013;
                7'd81: r = 16'h2014; 7'd82: r = 16'h201C; 7'd83: r = 16'h201D;
                7'd84: r = 16'h2018; 7'd85: r = 16'h2019; 7'd86: r = 16'h00F7;
                7'd87: r = 16'h25CA; 7'd88: r = 16'h00FF; 7'd89: r = 16'h0178;
                7'd90: r = 16'h2044; 7'd91: r = 16'h20AC; 7'd92: r = 16'h2039;
                7'd93: r = 16'h203A; 7'd94: r = 16'hFB01; 7'd95: r = 16'hFB02;
                7'd96: r = 16'h2021; 7'd97: r = 16'h00B7; 7'd98: r = 16'h201A;
                7'd99: r = 16'h201E; 7'd100: r = 16'h2030; 7'd101: r = 16'h00C2;
                7'd102: r = 16'h00CA; 7'd103: r = 16'h00C1; 7'd104: r = 16'h00CB;
                7'd105: r = 16'h00C8; 7'd106: r = 16'h00CD; 7'd107: r = 16'h00CE;
                7'd108: r = 16'h00CF; 7'd109: r = 16'h00CC; 7'd110: r = 16'h00D3;
                7'd111: r = 16'h00D4; 7'd112: r = 16'hF8FF; 7'd113: r = 16'h00D2;
                7'd114: r = 16'h00DA; 7'd115: r = 16'h00DB; 7'd116: r = 16'h00D9;
                7'd117: r = 16'h0131; 7'd118: r = 16'h02C6; 7'd119: r = 16'h02DC;
                7'd120: r = 16'h00AF; 7'd121: r = 16'h02D8; 7'd122: r = 16'h02D9;
                7'd123: r = 16'h02DA; 7'd124: r = 16'h00B8; 7'd125: r = 16'h02DD;
                7'd126: r = 16'h02DB; default: r = 16'h02C7;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* src/lttu_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lttu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;
    modport source (output valid, in_byte, stream_end, input ready);
    modport sink (input valid, in_byte, stream_end, output ready);
endinterface

interface lttu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    modport source (output valid, out_byte, out_last, input ready);
    modport sink (input valid, out_byte, out_last, output ready);
endinterface
`default_nettype wire

/* src/legacy_text_to_utf8_transcoder_unit.sv */
`timescale 1ns / 1ps
// Legacy text to UTF-8 transcoder.
// Requests enter on src (one source byte plus stream_end) and UTF-8 bytes
// leave on dst, one per cycle, with out_last on the final byte a request
// yields. Requests that yield nothing produce no output byte.
// The front end classifies a request in the cycle it is accepted and
// pushes it into a two-entry queue; it takes a request every cycle while
// the queue has room. The back end turns each queued entry into 0 to 6
// bytes at one byte per cycle while dst is ready; an entry with no
// output, and the empty first slot of a UTF-16 unit that completes
// without a pending high surrogate, are passed over without emitting
// a byte. The first byte of a request passes through the queue entry
// and the output register before it is presented on dst.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
// next edge and should be made while the block is idle.
// Reset clears the configuration to pass-through with no skipping and
// clears all stream state and the queue. When dst stalls, the output
// register holds its byte and the queue fills, after which src is held
// not ready until room frees up.
`default_nettype none
module legacy_text_to_utf8_transcoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [2:0] cfg_wdata,
    lttu_in_if.sink         src,
    lttu_out_if.source      dst
);
    lttu_pkg::work_t work, head;
    logic full, empty, pop, fire;

    assign src.ready = !full;
    assign fire = src.valid && !full;

    lttu_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_byte(src.in_byte), .stream_end(src.stream_end),
        .fire(fire), .work(work)
    );

    lttu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(fire), .push_data(work), .full(full),
        .pop(pop), .empty(empty), .head(head)
    );

    lttu_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .head(head), .pop(pop),
        .out_valid(dst.valid), .out_ready(dst.ready), .out_byte(dst.out_byte),
        .out_last(dst.out_last)
    );
endmodule
`default_nettype wire

/* src/lttu_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Applies skipping, table lookups and UTF-16 unit assembly; produces one work item per request.
module lttu_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [2:0]           cfg_wdata,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 stream_end,
    input  wire logic                 fire,
    output      lttu_pkg::work_t      work
);
    logic [2:0] enc_reg;
    logic [1:0] skip_reg;
    logic [1:0] skipped_reg, skipped_next;
    logic       have_reg, have_next;
    logic [7:0] first_reg, first_next;
    logic       hp_reg, hp_next;
    logic [9:0] hpay_reg, hpay_next;

    always_comb
    begin
        logic [15:0] unit;
        logic        hp;
        unit = 16'd0;
        hp = hp_reg;
        skipped_next = skipped_reg;
        have_next = have_reg;
        first_next = first_reg;
        hpay_next = hpay_reg;
        work = '0;
        work.raw_byte = in_byte;
        if (skipped_reg < skip_reg) begin
            skipped_next = skipped_reg + 2'd1;
        end else begin
            case (lttu_pkg::enc_t'(enc_reg))
                lttu_pkg::ENC_LATIN1:
                begin
                    work.cp0_en = 1'b1;
                    work.cp0 = {13'd0, in_byte};
                end
                lttu_pkg::ENC_LATIN9:
                begin
                    work.cp0_en = 1'b1;
                    case (in_byte)
                        8'hA4: work.cp0 = 21'h20AC;
                        8'hA6: work.cp0 = 21'h0160;
                        8'hA8: work.cp0 = 21'h0161;
                        8'hB4: work.cp0 = 21'h017D;
                        8'hB8: work.cp0 = 21'h017E;
                        8'hBC: work.cp0 = 21'h0152;
                        8'hBD: work.cp0 = 21'h0153;
                        8'hBE: work.cp0 = 21'h0178;
                        default: work.cp0 = {13'd0, in_byte};
                    endcase
                end
                lttu_pkg::ENC_CP1252:
                begin
                    work.cp0_en = 1'b1;
                    if (in_byte[7:5] == 3'b100)
                        work.cp0 = {5'd0, lttu_pkg::cp1252_map(in_byte[4:0])};
                    else
                        work.cp0 = {13'd0, in_byte};
                end
                lttu_pkg::ENC_MAC:
                begin
                    work.cp0_en = 1'b1;
                    if (in_byte[7])
                        work.cp0 = {5'd0, lttu_pkg::mac_map(in_byte[6:0])};
                    else
                        work.cp0 = {13'd0, in_byte};
                end
                lttu_pkg::ENC_UTF16LE, lttu_pkg::ENC_UTF16BE:
                begin
                    if (!have_reg) begin
                        have_next = 1'b1;
                        first_next = in_byte;
                    end else begin
                        have_next = 1'b0;
                        unit = (enc_reg == lttu_pkg::ENC_UTF16LE) ?
                               {in_byte, first_reg} : {first_reg, in_byte};
                        if (hp && unit[15:10] == 6'b110111) begin
                            work.cp0_en = 1'b1;
                            work.cp0 = {1'b0, hpay_reg, unit[9:0]} + 21'h010000;
                            hp = 1'b0;
                        end else begin
                            if (hp) begin
                                work.cp0_en = 1'b1;
                                work.cp0 = lttu_pkg::REPL_CHAR;
                                hp = 1'b0;
                            end
                            if (unit[15:10] == 6'b110110) begin
                                hp = 1'b1;
                                hpay_next = unit[9:0];
                            end else begin
                                work.cp1_en = 1'b1;
                                work.cp1 = (unit[15:10] == 6'b110111) ?
                                           lttu_pkg::REPL_CHAR : {5'd0, unit};
                            end
                        end
                    end
                end
                default: work.raw = 1'b1;
            endcase
        end
        if (stream_end) begin
            if (hp) begin
                // If a raw byte or a code point occupies the first slot, the flush goes second.
                if (work.cp0_en || work.raw) begin
                    work.cp1_en = 1'b1;
                    work.cp1 = lttu_pkg::REPL_CHAR;
                end else begin
                    work.cp0_en = 1'b1;
                    work.cp0 = lttu_pkg::REPL_CHAR;
                end
            end
            hp = 1'b0;
            have_next = 1'b0;
            skipped_next = 2'd0;
        end
        hp_next = hp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enc_reg <= 3'd0;
            skip_reg <= 2'd0;
            skipped_reg <= 2'd0;
            have_reg <= 1'b0;
            first_reg <= 8'd0;
            hp_reg <= 1'b0;
            hpay_reg <= 10'd0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == lttu_pkg::REG_SOURCE_ENCODING)
                    enc_reg <= cfg_wdata;
                else
                    skip_reg <= cfg_wdata[1:0];
            end
            if (fire) begin
                skipped_reg <= skipped_next;
                have_reg <= have_next;
                first_reg <= first_next;
                hp_reg <= hp_next;
                hpay_reg <= hpay_next;
            end
        end
    end
endmodule
`default_nettype wire

/* src/lttu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module lttu_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire lttu_pkg::work_t push_data,
    output      logic            full,
    input  wire logic            pop,
    output      logic            empty,
    output      lttu_pkg::work_t head
);
    lttu_pkg::work_t mem_reg [lttu_pkg::QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'(lttu_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == 2'd0);
    assign head = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* src/lttu_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Serializes a work item's raw byte or code points into UTF-8 bytes, one byte per cycle while the output slot is free.
module lttu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            empty,
    input  wire lttu_pkg::work_t head,
    output      logic            pop,
    output      logic            out_valid,
    input  wire logic            out_ready,
    output      logic [7:0]      out_byte,
    output      logic            out_last
);
    logic       sel_reg, sel_next;
    logic [1:0] idx_reg, idx_next;
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       ol_reg;

    logic [20:0] cp;
    logic [2:0]  nb;
    logic [7:0]  b;
    logic        has_cp, last_cp, cp_done, emit, item_done, slot_free, raw_now;

    always_comb
    begin
        cp = sel_reg ? head.cp1 : head.cp0;
        if (cp < 21'h80) nb = 3'd1;
        else if (cp < 21'h800) nb = 3'd2;
        else if (cp < 21'h10000) nb = 3'd3;
        else nb = 3'd4;
        case (nb)
            3'd1: b = cp[7:0];
            3'd2: b = (idx_reg == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                case (idx_reg)
                    2'd0: b = {4'b1110, cp[15:12]};
                    2'd1: b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx_reg)
                    2'd0: b = {5'b11110, cp[20:18]};
                    2'd1: b = {2'b10, cp[17:12]};
                    2'd2: b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        // A raw byte takes the place of the first code point.
        raw_now = head.raw && !sel_reg;
        has_cp = sel_reg ? head.cp1_en : head.cp0_en;
        cp_done = ({1'b0, idx_reg} == nb - 3'd1);
        last_cp = sel_reg || !head.cp1_en;
        slot_free = !ov_reg || out_ready;
        emit = 1'b0;
        item_done = 1'b0;
        sel_next = sel_reg;
        idx_next = idx_reg;
        if (!empty) begin
            if (raw_now) begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (head.cp1_en) sel_next = 1'b1;
                    else item_done = 1'b1;
                end
            end else if (!has_cp) begin
                // Empty item, or first code point absent: move on.
                if (!sel_reg && head.cp1_en)
                    sel_next = 1'b1;
                else
                    item_done = 1'b1;
            end else if (slot_free) begin
                emit = 1'b1;
                if (cp_done) begin
                    idx_next = 2'd0;
                    if (last_cp) item_done = 1'b1;
                    else sel_next = 1'b1;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
        if (item_done) begin
            sel_next = 1'b0;
            idx_next = 2'd0;
        end
        pop = item_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sel_reg <= 1'b0;
            idx_reg <= 2'd0;
            ov_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
            idx_reg <= idx_next;
            if (emit) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            ob_reg <= raw_now ? head.raw_byte : b;
            ol_reg <= raw_now ? !head.cp1_en : (cp_done && last_cp);
        end
    end

    assign out_valid = ov_reg;
    assign out_byte = ob_reg;
    assign out_last = ol_reg;
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } src_req_t;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } utf8_byte_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [2:0] cfg_wdata;

    lttu_in_if  src_ch ();
    lttu_out_if dst_ch ();

    legacy_text_to_utf8_transcoder_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .src(src_ch.sink),
        .dst(dst_ch.source)
    );

    localparam int WATCHDOG_LIMIT = 4000;

    src_req_t   pending_reqs[$];
    utf8_byte_t expected_utf8[$];

    // Predictor state and configuration.
    lttu_pkg::enc_t cur_enc;
    logic [1:0] cur_skip;
    logic [1:0] dropped_count;
    logic       half_held;
    logic [7:0] half_byte;
    logic       hi_surr_waiting;
    logic [9:0] hi_surr_bits;
    logic [7:0] step_bytes[$];

    int  error_count;
    int  req_count;
    int  byte_count;
    int  idle_cycles;
    bit  src_no_idle;
    bit  dst_no_idle;
    bit  dst_hold;
    int  hold_left;
    bit  src_taken;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [20:0] win_c1_cp(input logic [4:0] i);
        logic [15:0] t[32];
        t = '{16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020,
              16'h2021, 16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D,
              16'h017D, 16'h008F, 16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D,
              16'h2022, 16'h2013, 16'h2014, 16'h02DC, 16'h2122, 16'h0161, 16'h203A,
              16'h0153, 16'h009D, 16'h017E, 16'h0178};
        return {5'd0, t[i]};
    endfunction

    function automatic logic [20:0] mac_roman_cp(input logic [6:0] i);
        logic [15:0] t[128];
        t = '{16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC,
              16'h00E1, 16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7,
              16'h00E9, 16'h00E8, 16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE,
              16'h00EF, 16'h00F1, 16'h00F3, 16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5,
              16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC, 16'h2020, 16'h00B0, 16'h00A2,
              16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF, 16'h00AE, 16'h00A9,
              16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8, 16'h221E,
              16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
              16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6,
              16'h00F8, 16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248,
              16'h2206, 16'h00AB, 16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3,
              16'h00D5, 16'h0152, 16'h0153, 16'h2013, 16'h2014, 16'h201C, 16'h201D,
              16'h2018, 16'h2019, 16'h00F7, 16'h25CA, 16'h00FF, 16'h0178, 16'h2044,
              16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02, 16'h2021, 16'h00B7,
              16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1, 16'h00CB,
              16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
              16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6,
              16'h02DC, 16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD,
              16'h02DB, 16'h02C7};
        return {5'd0, t[i]};
    endfunction

    function automatic logic [20:0] latin9_cp(input logic [7:0] b);
        case (b)
            8'hA4: return 21'h20AC;
            8'hA6: return 21'h0160;
            8'hA8: return 21'h0161;
            8'hB4: return 21'h017D;
            8'hB8: return 21'h017E;
            8'hBC: return 21'h0152;
            8'hBD: return 21'h0153;
            8'hBE: return 21'h0178;
            default: return {13'd0, b};
        endcase
    endfunction

    task automatic encode_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            step_bytes.push_back(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            step_bytes.push_back({3'b110, cp[10:6]});
            step_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            step_bytes.push_back({4'b1110, cp[15:12]});
            step_bytes.push_back({2'b10, cp[11:6]});
            step_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            step_bytes.push_back({5'b11110, cp[20:18]});
            step_bytes.push_back({2'b10, cp[17:12]});
            step_bytes.push_back({2'b10, cp[11:6]});
            step_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    task automatic decode_utf16_unit(input logic [15:0] unit);
        bit is_hi;
        bit is_lo;
        is_hi = unit >= 16'hD800 && unit <= 16'hDBFF;
        is_lo = unit >= 16'hDC00 && unit <= 16'hDFFF;
        if (hi_surr_waiting)
        begin
            hi_surr_waiting = 1'b0;
            if (is_lo)
            begin
                encode_utf8(21'h10000 + {1'b0, hi_surr_bits, unit[9:0]});
                return;
            end
            encode_utf8(lttu_pkg::REPL_CHAR);
        end
        if (is_hi)
        begin
            hi_surr_waiting = 1'b1;
            hi_surr_bits = unit[9:0];
        end
        else if (is_lo)
            encode_utf8(lttu_pkg::REPL_CHAR);
        else
            encode_utf8({5'd0, unit});
    endtask

    // Work out the UTF-8 bytes one accepted request yields.
    task automatic transcode_request(input src_req_t r);
        int k;
        step_bytes.delete();
        if (dropped_count < cur_skip)
            dropped_count = dropped_count + 2'd1;
        else
        begin
            case (cur_enc)
                lttu_pkg::ENC_LATIN1: encode_utf8({13'd0, r.data});
                lttu_pkg::ENC_LATIN9: encode_utf8(latin9_cp(r.data));
                lttu_pkg::ENC_CP1252: encode_utf8((r.data >= 8'h80 && r.data <= 8'h9F) ?
                    win_c1_cp(r.data[4:0]) : {13'd0, r.data});
                lttu_pkg::ENC_MAC: encode_utf8(r.data[7] ? mac_roman_cp(r.data[6:0]) :
                    {13'd0, r.data});
                lttu_pkg::ENC_UTF16LE, lttu_pkg::ENC_UTF16BE:
                begin
                    if (!half_held)
                    begin
                        half_held = 1'b1;
                        half_byte = r.data;
                    end
                    else
                    begin
                        half_held = 1'b0;
                        decode_utf16_unit(cur_enc == lttu_pkg::ENC_UTF16LE ?
                            {r.data, half_byte} : {half_byte, r.data});
                    end
                end
                default: step_bytes.push_back(r.data);
            endcase
        end
        if (r.fin)
        begin
            if (hi_surr_waiting)
                encode_utf8(lttu_pkg::REPL_CHAR);
            hi_surr_waiting = 1'b0;
            half_held = 1'b0;
            dropped_count = 2'd0;
        end
        for (k = 0; k < step_bytes.size(); k++)
            expected_utf8.push_back('{step_bytes[k], k == step_bytes.size() - 1});
    endtask

    // Sender: offers queued requests, idling at random, and drives dst ready. An offered request
    // stays on the bus until it is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (src_taken)
                void'(pending_reqs.pop_front());
            if (!src_ch.valid || src_taken)
            begin
                if (pending_reqs.size() > 0 &&
                    (src_no_idle || $urandom_range(99) >= 30))
                begin
                    src_ch.valid      <= 1'b1;
                    src_ch.in_byte    <= pending_reqs[0].data;
                    src_ch.stream_end <= pending_reqs[0].fin;
                end
                else
                    src_ch.valid <= 1'b0;
            end
            if (hold_left > 0)
                dst_ch.ready <= 1'b0;
            else
                dst_ch.ready <= dst_no_idle || $urandom_range(99) >= 30;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (dst_hold)
            hold_left <= 200;
    end

    // Monitor: predicts on each accepted request, checks each output byte.
    always @(posedge clk)
    begin
        utf8_byte_t e;
        if (rst_n)
        begin
            src_taken <= src_ch.valid && src_ch.ready;
            if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (src_ch.valid && src_ch.ready)
            begin
                transcode_request('{src_ch.in_byte, src_ch.stream_end});
                req_count <= req_count + 1;
            end
            if (dst_ch.valid && dst_ch.ready)
            begin
                byte_count <= byte_count + 1;
                if (expected_utf8.size() == 0)
                begin
                    error_count <= error_count + 1;
                    $display("%0t: unexpected byte %h last %b", $time,
                             dst_ch.out_byte, dst_ch.out_last);
                end
                else
                begin
                    e = expected_utf8.pop_front();
                    if (e.data !== dst_ch.out_byte || e.fin !== dst_ch.out_last)
                    begin
                        error_count <= error_count + 1;
                        $display("%0t: expected %h last %b, actual %h last %b", $time,
                                 e.data, e.fin, dst_ch.out_byte, dst_ch.out_last);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [2:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == lttu_pkg::REG_SOURCE_ENCODING)
            cur_enc = lttu_pkg::enc_t'(val);
        else
            cur_skip = val[1:0];
    endtask

    // Wait until every request is taken and every byte has come out.
    task automatic drain;
        while (pending_reqs.size() > 0 || expected_utf8.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic add_req(input logic [7:0] d, input logic f);
        pending_reqs.push_back('{d, f});
    endtask

    // A UTF-16 stream with random units, surrogate pairs, lone and broken
    // surrogates, and one odd trailing byte that ends the stream.
    task automatic add_utf16_stream(input bit le, input int units);
        logic [15:0] u;
        int i;
        int pick;
        for (i = 0; i < units; i++)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                u = 16'(16'hD800 + $urandom_range(16'h3FF));
            else if (pick < 5)
                u = 16'(16'hDC00 + $urandom_range(16'h3FF));
            else
                u = 16'($urandom);
            add_req(le ? u[7:0] : u[15:8], 1'b0);
            add_req(le ? u[15:8] : u[7:0], 1'b0);
            if (pick < 2)
            begin
                u = 16'(16'hDC00 + $urandom_range(16'h3FF));
                add_req(le ? u[7:0] : u[15:8], 1'b0);
                add_req(le ? u[15:8] : u[7:0], 1'b0);
            end
        end
        add_req(8'($urandom), 1'b1);
    endtask

    initial
    begin
        int ph;
        int i;
        lttu_pkg::enc_t e;
        logic [1:0] sk;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        src_ch.valid = 1'b0;
        src_ch.in_byte = '0;
        src_ch.stream_end = 1'b0;
        dst_ch.ready = 1'b0;
        cur_enc = lttu_pkg::ENC_COPY;
        cur_skip = 2'd0;
        dropped_count = '0;
        half_held = 1'b0;
        half_byte = '0;
        hi_surr_waiting = 1'b0;
        hi_surr_bits = '0;
        error_count = 0;
        req_count = 0;
        byte_count = 0;
        idle_cycles = 0;
        src_no_idle = 1'b0;
        dst_no_idle = 1'b0;
        dst_hold = 1'b0;
        hold_left = 0;
        src_taken = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: copy at the extremes, then each table mode's edges.
        add_req(8'h00, 1'b0);
        add_req(8'hFF, 1'b1);
        drain();
        write_reg(lttu_pkg::REG_SOURCE_ENCODING, lttu_pkg::ENC_CP1252);
        add_req(8'h80, 1'b0);
        add_req(8'h9F, 1'b0);
        add_req(8'hA0, 1'b1);
        drain();
        write_reg(lttu_pkg::REG_SOURCE_ENCODING, lttu_pkg::ENC_MAC);
        add_req(8'hF0, 1'b0);
        add_req(8'h7F, 1'b1);
        drain();
        write_reg(lttu_pkg::REG_SOURCE_ENCODING, lttu_pkg::ENC_LATIN9);
        add_req(8'hA4, 1'b0);
        add_req(8'hBE, 1'b1);
        drain();
        write_reg(lttu_pkg::REG_SOURCE_ENCODING, lttu_pkg::ENC_UTF16BE);
        write_reg(lttu_pkg::REG_SKIP_COUNT, 3'd2);
        // Skipped mark, pair to U+10FFFF, lone low, high then BMP, odd byte.
        add_req(8'hFE, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(8'hDB, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(8'hDF, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(8'hDC, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'hD8, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'h41, 1'b0);
        add_req(8'hD8, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'h12, 1'b1);
        drain();
        write_reg(lttu_pkg::REG_SOURCE_ENCODING, lttu_pkg::ENC_OTHER);
        write_reg(lttu_pkg::REG_SKIP_COUNT, 3'd3);
        for (i = 0; i < 5; i++)
            add_req(8'(8'h10 * i), i == 4);
        drain();

        // Random phases over random modes and skip counts 0, 1 and 3.
        for (ph = 0; ph < 14; ph++)
        begin
            e = lttu_pkg::enc_t'($urandom_range(7));
            sk = (ph % 4 == 0) ? 2'd3 : 2'($urandom_range(1));
            write_reg(lttu_pkg::REG_SOURCE_ENCODING, e);
            write_reg(lttu_pkg::REG_SKIP_COUNT, {1'b0, sk});
            src_no_idle = (ph == 4);
            dst_no_idle = (ph == 4);
            if (e == lttu_pkg::ENC_UTF16LE || e == lttu_pkg::ENC_UTF16BE)
            begin
                add_utf16_stream(e == lttu_pkg::ENC_UTF16LE, 4 + $urandom_range(6));
                add_utf16_stream(e == lttu_pkg::ENC_UTF16LE, 2 + $urandom_range(4));
            end
            else
            begin
                for (i = 0; i < 22; i++)
                    add_req(8'($urandom), $urandom_range(7) == 0 || i == 21);
            end
            if (ph == 6)
            begin
                // Block the output for a long stretch while requests keep coming.
                dst_hold = 1'b1;
                @(negedge clk);
                dst_hold = 1'b0;
            end
            drain();
        end
        drain();
        $display("Covered %0d requests yielding %0d UTF-8 bytes over all source modes,",
                 req_count, byte_count);
        $display("skip counts, surrogate pairing, stream flushes and output stalls.");
        if (error_count == 0 && expected_utf8.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
